### src/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and the CORDIC arctangent table for the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int CORDIC_MAX_ITER = 24;

  localparam int SAMPLE_W = 16;
  localparam int CORR_W = 17;
  localparam int ANGLE_W = 17;
  localparam int ACC_W = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam int LIM180 = 180 << ANGLE_FRAC_BITS;
  localparam int LIM90 = 90 << ANGLE_FRAC_BITS;
  localparam int ANGLE_RESET = 38 << ANGLE_FRAC_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z_LIMIT = 3'd6;

  typedef struct packed {
    logic signed [10:0] gyro_offset;
    logic signed [12:0] accel_y_offset;
    logic signed [12:0] accel_z_offset;
    logic [15:0]        gyro_gain;
    logic [15:0]        accel_weight;
    logic signed [12:0] accel_y_limit;
    logic signed [12:0] accel_z_limit;
  } cfg_t;

  // corrected sample; ay/az are the magnitudes of the clamped (negative) axes
  typedef struct packed {
    logic signed [CORR_W-1:0] g;
    logic [CORR_W-1:0]        ay;
    logic [CORR_W-1:0]        az;
  } item_t;

  typedef struct packed {
    logic  push;
    logic  full;
  } q_ctl_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### src/tcf_front.sv
// ----------------------------------------------------------------------------
// tcf_front
// Input side: applies offsets, clamps the accel axes and queues the sample.
// ----------------------------------------------------------------------------
module tcf_front import tcf_pkg::*; (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  input  cfg_t        cfg,
  input  logic        q_full,
  output q_ctl_t      q_ctl,
  output item_t       q_item
);

  logic signed [CORR_W-1:0] g, ay, az, ylim, zlim, ayc, azc;

  always_comb begin
    g  = CORR_W'($signed(s_tdata[15:0])) + CORR_W'(cfg.gyro_offset);
    ay = CORR_W'($signed(s_tdata[31:16])) + CORR_W'(cfg.accel_y_offset);
    az = CORR_W'($signed(s_tdata[47:32])) + CORR_W'(cfg.accel_z_offset);
    // a non-negative limit acts as -1
    ylim = cfg.accel_y_limit[12] ? CORR_W'(cfg.accel_y_limit) : -17'sd1;
    zlim = cfg.accel_z_limit[12] ? CORR_W'(cfg.accel_z_limit) : -17'sd1;
    ayc = (ay > ylim) ? ylim : ay;
    azc = (az > zlim) ? zlim : az;
    q_item.g  = g;
    q_item.ay = $unsigned(-ayc);
    q_item.az = $unsigned(-azc);
  end

  assign s_tready   = !q_full;
  assign q_ctl.push = s_tvalid && !q_full;
  assign q_ctl.full = q_full;

endmodule

### src/tcf_fifo.sv
// ----------------------------------------------------------------------------
// tcf_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module tcf_fifo import tcf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  q_ctl_t q_ctl,
  input  item_t  wr_item,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output item_t  rd_item
);

  item_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      mem[wr_ptr] <= wr_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_ctl.push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(q_ctl.push) - 2'(pop);
    end
  end

endmodule

### src/tcf_back.sv
// ----------------------------------------------------------------------------
// tcf_back
// Execution side: gyro prediction, CORDIC atan, blend and output register.
// ----------------------------------------------------------------------------
module tcf_back import tcf_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata
);

  localparam int NIT = (CORDIC_ITERATIONS > CORDIC_MAX_ITER) ?
                       CORDIC_MAX_ITER : CORDIC_ITERATIONS;
  localparam int CW = $clog2(NIT);
  localparam int GSH = 24 - ANGLE_FRAC_BITS;
  localparam int ASH = 16 - ANGLE_FRAC_BITS;
  localparam int XW = 44;

  typedef enum logic [2:0] {
    S_IDLE, S_GYRO, S_CORDIC, S_ACC, S_MUL, S_SUM
  } state_t;

  state_t state;
  logic [CW-1:0] cnt;

  logic signed [ANGLE_W-1:0] angle, pred, tilt, pred_o;
  logic [ACC_W-1:0]          acc, acc_o;
  logic signed [33:0]        gprod;
  logic signed [XW-1:0]      cx, cy;
  logic signed [25:0]        cz;
  logic signed [34:0]        bprod1;
  logic [30:0]               bprod2;

  // combinational helpers
  logic signed [XW-1:0] dx, dy;
  logic [25:0]          zat;
  logic [33:0]          gmag;
  logic [18:0]          grnd;
  logic signed [19:0]   pred_raw;
  logic [25:0]          zmag;
  logic [18:0]          zrnd;
  logic signed [19:0]   acc_raw;
  logic signed [36:0]   bsum;
  logic [36:0]          bmag;
  logic [21:0]          brnd;
  logic signed [22:0]   blend;
  logic [16:0]          wcomp;

  always_comb begin
    dx  = cy >>> cnt;
    dy  = cx >>> cnt;
    zat = 26'(atan_lut(5'(cnt)));

    gmag     = gprod[33] ? 34'($unsigned(-gprod)) : 34'($unsigned(gprod));
    grnd     = 19'((gmag + 34'(1 << (GSH - 1))) >> GSH);
    // delta is the negated product, rounded half away from zero
    pred_raw = 20'(angle) + (gprod[33] ? $signed({1'b0, grnd}) : -$signed({1'b0, grnd}));

    zmag    = cz[25] ? 26'($unsigned(-cz)) : 26'($unsigned(cz));
    zrnd    = 19'((zmag + 26'(1 << (ASH - 1))) >> ASH);
    acc_raw = cz[25] ? -$signed({1'b0, zrnd}) : $signed({1'b0, zrnd});

    wcomp = 17'd65536 - {1'b0, cfg.accel_weight};
    bsum  = 37'(bprod1) + $signed({6'd0, bprod2});
    bmag  = bsum[36] ? 37'($unsigned(-bsum)) : 37'($unsigned(bsum));
    brnd  = 22'((bmag + 37'(1 << 15)) >> 16);
    blend = bsum[36] ? -$signed({1'b0, brnd}) : $signed({1'b0, brnd});
  end

  assign pop = (state == S_IDLE) && !q_empty;
  assign m_tdata = {7'd0, acc_o, $unsigned(pred_o), $unsigned(tilt)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      angle    <= ANGLE_W'(ANGLE_RESET);
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_SUM)) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            gprod <= q_item.g * $signed({1'b0, cfg.gyro_gain});
            cx    <= $signed({3'd0, q_item.ay, 24'd0});
            cy    <= $signed({3'd0, q_item.az, 24'd0});
            cz    <= '0;
            cnt   <= '0;
            state <= S_GYRO;
          end
        end
        S_GYRO: begin
          if (pred_raw > 20'sd46080) pred <= ANGLE_W'(LIM180);
          else if (pred_raw < -20'sd46080) pred <= -ANGLE_W'(LIM180);
          else pred <= 17'(pred_raw);
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cy[XW-1]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + $signed(zat);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - $signed(zat);
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NIT - 1)) state <= S_ACC;
        end
        S_ACC: begin
          if (acc_raw < 20'sd0) acc <= '0;
          else if (acc_raw > 20'sd23040) acc <= ACC_W'(LIM90);
          else acc <= 15'(acc_raw);
          state <= S_MUL;
        end
        S_MUL: begin
          bprod1 <= $signed({1'b0, wcomp}) * pred;
          bprod2 <= cfg.accel_weight * acc;
          state  <= S_SUM;
        end
        S_SUM: begin
          if (!m_tvalid || m_tready) begin
            if (blend > 23'sd46080) begin
              tilt <= ANGLE_W'(LIM180); angle <= ANGLE_W'(LIM180);
            end else if (blend < -23'sd46080) begin
              tilt <= -ANGLE_W'(LIM180); angle <= -ANGLE_W'(LIM180);
            end else begin
              tilt <= 17'(blend); angle <= 17'(blend);
            end
            // result fields held here while the next sample is worked on
            pred_o   <= pred;
            acc_o    <= acc;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Complementary filter fusing gyro rate and accel atan into a tilt angle.
//
//   channel  dir  fields (lsb first)
//   s_*      in   gyro_rate[15:0] accel_y[31:16] accel_z[47:32]
//   m_*      out  tilt_angle[16:0] gyro_angle[33:17] accel_angle[48:34]
//   cfg_*    in   index 0..6, data 16b, write-only
//
// The back end steps each sample through the gyro, iterative CORDIC, clamp,
// multiply and sum states, popping no new one until done. A two-entry queue
// lets the input take samples while the back end is busy or the output stalls.
// Reset is synchronous; the stored angle comes back as 38 degrees.
// ----------------------------------------------------------------------------
module tilt_complementary_filter import tcf_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // gyro_rate, accel_y, accel_z
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // tilt_angle, gyro_angle, accel_angle
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  q_ctl_t q_ctl;
  item_t  wr_item, rd_item;
  logic   q_full, q_empty, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_offset    <= 11'sd34;
      cfg.accel_y_offset <= 13'sd37;
      cfg.accel_z_offset <= 13'sd268;
      cfg.gyro_gain      <= 16'd10230;
      cfg.accel_weight   <= 16'd2949;
      cfg.accel_y_limit  <= -13'sd700;
      cfg.accel_z_limit  <= -13'sd300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GYRO_OFFSET:    cfg.gyro_offset    <= cfg_wdata[10:0];
        REG_ACCEL_Y_OFFSET: cfg.accel_y_offset <= cfg_wdata[12:0];
        REG_ACCEL_Z_OFFSET: cfg.accel_z_offset <= cfg_wdata[12:0];
        REG_GYRO_GAIN:      cfg.gyro_gain      <= cfg_wdata;
        REG_ACCEL_WEIGHT:   cfg.accel_weight   <= cfg_wdata;
        REG_ACCEL_Y_LIMIT:  cfg.accel_y_limit  <= cfg_wdata[12:0];
        REG_ACCEL_Z_LIMIT:  cfg.accel_z_limit  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  tcf_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_ctl    (q_ctl),
    .q_item   (wr_item)
  );

  tcf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .q_ctl   (q_ctl),
    .wr_item (wr_item),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .rd_item (rd_item)
  );

  tcf_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_item   (rd_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty) else $error("pop from empty queue");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !s_tready) else $error("ready while queue full");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48:34] <= 15'd23040)) else $error("accel angle out of range");

endmodule
